### rtl/core/bounded_stack_second_largest_unit_assert.svh
// Assertion macros for the checker file of the stack unit.
// Depends on nothing; include by bare file name.
`ifndef BOUNDED_STACK_SECOND_LARGEST_UNIT_ASSERT_SVH
`define BOUNDED_STACK_SECOND_LARGEST_UNIT_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted (active-low reset).
`define BSSL_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define BSSL_ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/bssl_pkg.sv
// Package for the bounded stack unit: sizes, codes, state type and the
// control structs passed to the rank unit. No dependencies.
`default_nettype none
package bssl_pkg;

  localparam int DEPTH  = 256;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int CAP_W  = 9;
  localparam int REQ_W  = 2;
  localparam int STAT_W = 3;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_OVERFLOW  = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_FEW       = 3'd3,
    STAT_NO_SECOND = 3'd4
  } status_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NOP   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_TOP,
    S_SCAN,
    S_QEND,
    S_FIN
  } state_t;

  typedef struct packed {
    logic                     en;
    logic                     first;
    logic signed [WORD_W-1:0] data;
  } rank_in_t;

  typedef struct packed {
    logic                     have;
    logic signed [WORD_W-1:0] second;
  } rank_out_t;

endpackage
`default_nettype wire

### rtl/core/bssl_rank.sv
// Compare unit for the second-largest scan: tracks the running
// maximum and the largest value strictly below it. Uses bssl_pkg.
`default_nettype none
module bssl_rank (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire bssl_pkg::rank_in_t  ctl,
  output bssl_pkg::rank_out_t      res
);
  import bssl_pkg::*;

  logic signed [WORD_W-1:0] largest_r, largest_nxt;
  logic signed [WORD_W-1:0] second_r, second_nxt;
  logic                     have_r, have_nxt;

  always_comb begin
    largest_nxt = largest_r;
    second_nxt  = second_r;
    have_nxt    = have_r;
    if (ctl.en) begin
      if (ctl.first) begin
        largest_nxt = ctl.data;
        have_nxt    = 1'b0;
      end else if (ctl.data > largest_r) begin
        // old maximum drops to second place
        second_nxt  = largest_r;
        have_nxt    = 1'b1;
        largest_nxt = ctl.data;
      end else if ((ctl.data != largest_r) && (!have_r || (ctl.data > second_r))) begin
        second_nxt = ctl.data;
        have_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else begin
      have_r <= have_nxt;
    end
    largest_r <= largest_nxt;
    second_r  <= second_nxt;
  end

  assign res.have   = have_r;
  assign res.second = second_r;

endmodule
`default_nettype wire

### rtl/core/bounded_stack_second_largest_unit.sv
// Path from accept to out_valid: push, no-op, a pop on an empty stack and a query with
// fewer than two entries go straight to S_FIN; other pops pass S_POP_TOP first; other
// queries scan in S_SCAN, then pass S_QEND. Throughput: one item at a time; in_stall is
// high until S_FIN hands the result to the output, and S_FIN waits while an earlier result is stalled.
// Reset (synchronous, rst_n low): stack empty, capacity 256, no result pending.
// A query walks the stack one entry per cycle; memory is never cleared.
`default_nettype none
module bounded_stack_second_largest_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [bssl_pkg::REQ_W-1:0]    in_req_type,
  input  wire logic signed [bssl_pkg::WORD_W-1:0] in_push_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [bssl_pkg::STAT_W-1:0]        out_status,
  output logic signed [bssl_pkg::WORD_W-1:0] out_result_value,
  output logic signed [bssl_pkg::WORD_W-1:0] out_top_value,
  output logic                               out_is_empty,
  output logic [bssl_pkg::CNT_W-1:0]         out_depth_now,
  input  wire logic                          cfg_wr_en,
  input  wire logic [bssl_pkg::CAP_W-1:0]    cfg_wr_data
);
  import bssl_pkg::*;

  state_t state_r, state_nxt;

  logic [CAP_W-1:0]         cap_r;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic signed [WORD_W-1:0] top_r, top_nxt;
  logic [ADDR_W-1:0]        cons_r, cons_nxt;
  logic                     first_r, first_nxt;
  status_t                  pend_status_r, pend_status_nxt;
  logic signed [WORD_W-1:0] pend_value_r, pend_value_nxt;

  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic signed [WORD_W-1:0] out_result_r, out_result_nxt;
  logic signed [WORD_W-1:0] out_top_r, out_top_nxt;
  logic                     out_empty_r, out_empty_nxt;
  logic [CNT_W-1:0]         out_depth_r, out_depth_nxt;

  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rdata_r;
  logic [ADDR_W-1:0]        raddr;
  logic                     mem_we;

  rank_in_t  rank_ctl;
  rank_out_t rank_res;

  logic             in_accept;
  logic             out_free;
  logic             full;
  logic             scan_last;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] cnt_m2;
  req_t             req;

  assign req       = req_t'(in_req_type);
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign full      = (CAP_W'(count_r) >= cap_r) || (count_r >= CNT_W'(DEPTH));
  assign cnt_m1    = count_r - CNT_W'(1);
  assign cnt_m2    = count_r - CNT_W'(2);
  assign scan_last = (cons_r == cnt_m1[ADDR_W-1:0]);

  bssl_rank u_rank (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (rank_ctl),
    .res   (rank_res)
  );

  // read address: next top on pop, entry 0 on query start, walk during scan
  always_comb begin
    raddr = cons_r + ADDR_W'(1);
    if (state_r == S_IDLE) begin
      if (req == REQ_POP) begin
        raddr = cnt_m2[ADDR_W-1:0];
      end else begin
        raddr = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[ADDR_W-1:0]] <= in_push_value;
    end
    rdata_r <= mem[raddr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          case (req)
            REQ_POP:   state_nxt = (count_r == '0) ? S_FIN : S_POP_TOP;
            REQ_QUERY: state_nxt = (count_r < CNT_W'(2)) ? S_FIN : S_SCAN;
            default:   state_nxt = S_FIN;
          endcase
        end
      end
      S_POP_TOP: state_nxt = S_FIN;
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = S_QEND;
        end
      end
      S_QEND: state_nxt = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_nxt       = count_r;
    top_nxt         = top_r;
    cons_nxt        = cons_r;
    first_nxt       = first_r;
    pend_status_nxt = pend_status_r;
    pend_value_nxt  = pend_value_r;
    mem_we          = 1'b0;
    rank_ctl.en     = 1'b0;
    rank_ctl.first  = first_r;
    rank_ctl.data   = rdata_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_result_nxt  = out_result_r;
    out_top_nxt     = out_top_r;
    out_empty_nxt   = out_empty_r;
    out_depth_nxt   = out_depth_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          pend_status_nxt = STAT_OK;
          pend_value_nxt  = '0;
          case (req)
            REQ_PUSH: begin
              if (full) begin
                pend_status_nxt = STAT_OVERFLOW;
              end else begin
                mem_we    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                top_nxt   = in_push_value;
              end
            end
            REQ_POP: begin
              if (count_r == '0) begin
                pend_status_nxt = STAT_EMPTY;
              end else begin
                pend_value_nxt = top_r;
                count_nxt      = cnt_m1;
              end
            end
            REQ_QUERY: begin
              if (count_r < CNT_W'(2)) begin
                pend_status_nxt = STAT_FEW;
              end else begin
                cons_nxt  = '0;
                first_nxt = 1'b1;
              end
            end
            default: begin
              pend_status_nxt = STAT_OK;
            end
          endcase
        end
      end
      S_POP_TOP: begin
        // count already dropped; an emptied stack shows zero on top
        top_nxt = (count_r == '0) ? '0 : rdata_r;
      end
      S_SCAN: begin
        rank_ctl.en = 1'b1;
        first_nxt   = 1'b0;
        cons_nxt    = cons_r + ADDR_W'(1);
      end
      S_QEND: begin
        if (rank_res.have) begin
          pend_status_nxt = STAT_OK;
          pend_value_nxt  = rank_res.second;
        end else begin
          pend_status_nxt = STAT_NO_SECOND;
          pend_value_nxt  = '0;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_status_r;
          out_result_nxt = pend_value_r;
          out_top_nxt    = top_r;
          out_empty_nxt  = (count_r == '0);
          out_depth_nxt  = count_r;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_W'(DEPTH);
      count_r     <= '0;
      top_r       <= '0;
      cons_r      <= '0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      top_r       <= top_nxt;
      cons_r      <= cons_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
    pend_status_r <= pend_status_nxt;
    pend_value_r  <= pend_value_nxt;
    out_status_r  <= out_status_nxt;
    out_result_r  <= out_result_nxt;
    out_top_r     <= out_top_nxt;
    out_empty_r   <= out_empty_nxt;
    out_depth_r   <= out_depth_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_result_r;
  assign out_top_value    = out_top_r;
  assign out_is_empty     = out_empty_r;
  assign out_depth_now    = out_depth_r;

endmodule
`default_nettype wire

### rtl/core/bssl_checker.sv
// Port-level checker for the bounded stack unit, bound to the top level.
// Uses bssl_pkg and the assertion macros header.
`default_nettype none
`include "bounded_stack_second_largest_unit_assert.svh"
module bssl_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire logic [bssl_pkg::STAT_W-1:0]        out_status,
  input wire logic signed [bssl_pkg::WORD_W-1:0] out_result_value,
  input wire logic signed [bssl_pkg::WORD_W-1:0] out_top_value,
  input wire logic                               out_is_empty,
  input wire logic [bssl_pkg::CNT_W-1:0]         out_depth_now
);
  import bssl_pkg::*;

  `BSSL_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result item dropped while stalled")
  `BSSL_ASSERT_RST(a_empty_depth, clk, rst_n, out_valid |-> (out_is_empty == (out_depth_now == '0)), "empty flag disagrees with depth")
  `BSSL_ASSERT_RST(a_empty_top, clk, rst_n, out_valid && out_is_empty |-> (out_top_value == '0), "nonzero top on empty stack")
  `BSSL_ASSERT_RST(a_err_zero, clk, rst_n, out_valid && (out_status != STAT_OK) |-> (out_result_value == '0), "error result carries a value")
  `BSSL_ASSERT_RST(a_depth_max, clk, rst_n, out_valid |-> (out_depth_now <= CNT_W'(DEPTH)), "depth beyond stack size")

endmodule

bind bounded_stack_second_largest_unit bssl_checker u_bssl_checker (.*);
`default_nettype wire

### tb/bounded_stack_second_largest_unit_test.sv
// Self-checking testbench for bounded_stack_second_largest_unit: directed and random
// push, pop and second-largest requests, each result checked against a stack predictor.
// Depends on bssl_pkg and the unit RTL; needs no files or arguments.

typedef struct packed {
  bssl_pkg::status_t                  status;
  logic signed [bssl_pkg::WORD_W-1:0] value;
  logic signed [bssl_pkg::WORD_W-1:0] top;
  logic                               empty;
  logic [bssl_pkg::CNT_W-1:0]         depth;
} stack_result_t;

class stack_scoreboard;
  logic signed [bssl_pkg::WORD_W-1:0] entries [bssl_pkg::DEPTH];
  int unsigned                        count;
  int unsigned                        capacity;
  stack_result_t                      waiting_q [$];
  int unsigned                        mismatches;
  int unsigned                        req_seen [4];
  int unsigned                        status_seen [5];
  int unsigned                        deepest;

  function new();
    count      = 0;
    capacity   = bssl_pkg::DEPTH;
    mismatches = 0;
    deepest    = 0;
  endfunction

  function void set_capacity(logic [bssl_pkg::CAP_W-1:0] cap);
    capacity = cap;
  endfunction

  function int unsigned waiting();
    return waiting_q.size();
  endfunction

  // Apply one accepted request to the shadow stack and queue the result it gives.
  function void note_item(bssl_pkg::req_t req, logic signed [bssl_pkg::WORD_W-1:0] word);
    stack_result_t                      want;
    int unsigned                        room;
    int unsigned                        i;
    logic signed [bssl_pkg::WORD_W-1:0] largest;
    logic signed [bssl_pkg::WORD_W-1:0] second;
    bit                                 have_second;
    want        = '0;
    want.status = bssl_pkg::STAT_OK;
    // capacity above the physical depth is clipped
    room = (capacity > bssl_pkg::DEPTH) ? bssl_pkg::DEPTH : capacity;
    case (req)
      bssl_pkg::REQ_PUSH: begin
        if (count >= room) begin
          want.status = bssl_pkg::STAT_OVERFLOW;
        end else begin
          entries[count] = word;
          count++;
        end
      end
      bssl_pkg::REQ_POP: begin
        if (count == 0) begin
          want.status = bssl_pkg::STAT_EMPTY;
        end else begin
          count--;
          want.value = entries[count];
        end
      end
      bssl_pkg::REQ_QUERY: begin
        if (count < 2) begin
          want.status = bssl_pkg::STAT_FEW;
        end else begin
          largest     = entries[0];
          second      = '0;
          have_second = 1'b0;
          for (i = 1; i < count; i++) begin
            if (entries[i] > largest) begin
              second      = largest;
              have_second = 1'b1;
              largest     = entries[i];
            end else if (entries[i] != largest && (!have_second || entries[i] > second)) begin
              second      = entries[i];
              have_second = 1'b1;
            end
          end
          if (have_second) begin
            want.value = second;
          end else begin
            want.status = bssl_pkg::STAT_NO_SECOND;
          end
        end
      end
      default: ;
    endcase
    want.top   = (count == 0) ? '0 : entries[count - 1];
    want.empty = (count == 0);
    want.depth = count[bssl_pkg::CNT_W-1:0];
    req_seen[req]++;
    status_seen[want.status]++;
    if (count > deepest) deepest = count;
    waiting_q.push_back(want);
  endfunction

  function void check_result(stack_result_t got);
    stack_result_t want;
    if (waiting_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: status %0d value %0d top %0d empty %0b depth %0d",
                 got.status, got.value, got.top, got.empty, got.depth);
      return;
    end
    want = waiting_q.pop_front();
    if (got.status !== want.status || got.value !== want.value || got.top !== want.top ||
        got.empty !== want.empty || got.depth !== want.depth) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result mismatch: want status %0d value %0d top %0d empty %0b depth %0d",
                 want.status, want.value, want.top, want.empty, want.depth);
        $display("                 got  status %0d value %0d top %0d empty %0b depth %0d",
                 got.status, got.value, got.top, got.empty, got.depth);
      end
    end
  endfunction
endclass

module bounded_stack_second_largest_unit_test;
  import bssl_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 300;
  localparam int HOLD_AFTER     = 60;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [REQ_W-1:0]         in_req_type;
  logic signed [WORD_W-1:0] in_push_value;
  logic                     out_valid;
  logic                     out_stall;
  logic [STAT_W-1:0]        out_status;
  logic signed [WORD_W-1:0] out_result_value;
  logic signed [WORD_W-1:0] out_top_value;
  logic                     out_is_empty;
  logic [CNT_W-1:0]         out_depth_now;
  logic                     cfg_wr_en;
  logic [CAP_W-1:0]         cfg_wr_data;

  stack_scoreboard sb = new();
  int unsigned     quiet_cycles = 0;
  int unsigned     results_seen = 0;
  bit              rx_idling = 1'b0;
  bit              long_hold_done = 1'b0;

  bounded_stack_second_largest_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_result_value (out_result_value),
    .out_top_value    (out_top_value),
    .out_is_empty     (out_is_empty),
    .out_depth_now    (out_depth_now),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin : watch_ports
    stack_result_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_item(req_t'(in_req_type), in_push_value);
      if (out_valid && !out_stall) begin
        got.status = status_t'(out_status);
        got.value  = out_result_value;
        got.top    = out_top_value;
        got.empty  = out_is_empty;
        got.depth  = out_depth_now;
        sb.check_result(got);
        results_seen <= results_seen + 1;
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : result_side
    int unsigned burst;
    burst     = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        // hold off long enough for the unit to back up and stall its input
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
      end else if (burst != 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (rx_idling && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 16) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    do @(posedge clk); while (quiet_cycles < WATCHDOG_LIMIT);
    $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(input req_t req, input logic [WORD_W-1:0] word);
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_push_value <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.waiting() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_capacity(cap);
  endtask

  function automatic logic [WORD_W-1:0] pick_word(input bit narrow);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 32'h8000_0000;
    if (pick == 1) return 32'h7fff_ffff;
    // few distinct values so queries often see duplicates of the maximum
    if (narrow) return (pick < 7) ? 32'd5 : 32'hffff_fff9;
    if (pick < 4) return 32'($urandom_range(0, 4)) - 32'd2;
    return 32'($urandom());
  endfunction

  task automatic run_traffic(input int items, input int w_push, input int w_pop,
                             input int w_query, input bit narrow, input bit idling);
    int   n;
    int   roll;
    req_t req;
    for (n = 0; n < items; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < w_push) req = REQ_PUSH;
      else if (roll < w_push + w_pop) req = REQ_POP;
      else if (roll < w_push + w_pop + w_query) req = REQ_QUERY;
      else req = REQ_NOP;
      if (idling && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 16));
      send_item(req, pick_word(narrow));
    end
  endtask

  initial begin : stimulus
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = REQ_NOP;
    in_push_value = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    rx_idling = 1'b1;

    // empty stack, one entry, equal entries, extreme words
    send_item(REQ_POP, '0);
    send_item(REQ_QUERY, 32'hffff_ffff);
    send_item(REQ_NOP, 32'h1234_5678);
    send_item(REQ_PUSH, 32'h7fff_ffff);
    send_item(REQ_QUERY, '0);
    send_item(REQ_PUSH, 32'h7fff_ffff);
    send_item(REQ_QUERY, '0);
    send_item(REQ_PUSH, 32'h8000_0000);
    send_item(REQ_PUSH, 32'hffff_ffff);
    send_item(REQ_PUSH, 32'h0000_0000);
    send_item(REQ_QUERY, '0);
    repeat (6) send_item(REQ_POP, 32'h5555_5555);
    drain_results();

    // small capacity, then zero capacity below the current depth
    write_capacity(9'd2);
    send_item(REQ_PUSH, 32'd11);
    send_item(REQ_PUSH, 32'hffff_fffd);
    send_item(REQ_PUSH, 32'd4);
    send_item(REQ_QUERY, '0);
    drain_results();
    write_capacity(9'd0);
    send_item(REQ_PUSH, 32'd9);
    send_item(REQ_POP, '0);
    send_item(REQ_POP, '0);
    drain_results();

    // fill to full depth, then drain with capacity beyond the depth
    write_capacity(9'd256);
    run_traffic(420, 82, 6, 10, 1'b0, 1'b1);
    drain_results();
    write_capacity(9'd511);
    rx_idling = 1'b0;
    run_traffic(250, 10, 80, 8, 1'b0, 1'b0);
    drain_results();

    rx_idling = 1'b1;
    write_capacity(9'd1);
    run_traffic(120, 20, 70, 8, 1'b1, 1'b1);
    drain_results();
    write_capacity(9'd3);
    run_traffic(100, 45, 35, 18, 1'b1, 1'b1);
    drain_results();
    run_traffic(100, 45, 35, 18, 1'b1, 1'b1);
    drain_results();
    write_capacity(9'($urandom_range(4, 300)));
    run_traffic(150, 50, 35, 13, 1'b0, 1'b1);
    drain_results();

    // closing stretch at full rate
    write_capacity(9'd8);
    rx_idling = 1'b0;
    run_traffic(100, 45, 35, 18, 1'b1, 1'b0);
    drain_results();
    repeat (8) @(negedge clk);

    $display("covered %0d pushes, %0d pops, %0d queries, %0d no-ops; deepest stack %0d",
             sb.req_seen[REQ_PUSH], sb.req_seen[REQ_POP], sb.req_seen[REQ_QUERY],
             sb.req_seen[REQ_NOP], sb.deepest);
    $display("overflows %0d, empty pops %0d, short queries %0d, no second %0d, mismatches %0d",
             sb.status_seen[STAT_OVERFLOW], sb.status_seen[STAT_EMPTY],
             sb.status_seen[STAT_FEW], sb.status_seen[STAT_NO_SECOND], sb.mismatches);
    if (sb.mismatches == 0 && sb.waiting() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
